### rtl/core/chunked_transfer_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef CHUNKED_TRANSFER_DECODER_MACROS_SVH
`define CHUNKED_TRANSFER_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

### rtl/core/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, codes and helpers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int CTD_SIZE_BITS = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NODIGIT  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic [2:0] status;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

### rtl/core/chunked_transfer_decoder.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Streaming decoder for a chunked transfer-coded body, one byte per item.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  input   | i_valid / o_ready  | i_data : t_in  (in_byte, in_end)
//  output  | o_valid / i_ready  | o_data : t_out (byte, kind, status, last)
//
// One byte is parsed per cycle while o_ready is high; results are registered
// into a 4-entry output queue.
// A final byte inside chunk data makes two results; with the receiver ready
// the queue never fills, so one byte is taken every cycle.
// o_ready drops while the queue holds more than two results.
// i_rst_n is synchronous: parse state returns to the start of a size
// line and the queue empties.
`include "chunked_transfer_decoder_macros.svh"

module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = CTD_SIZE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int FifoDepth = 4;
    localparam int PtrBits   = $clog2(FifoDepth);
    localparam int CntBits   = $clog2(FifoDepth + 1);

    typedef enum logic [3:0] {
        PH_START, PH_LEAD, PH_DIGITS, PH_SKIP, PH_CR,
        PH_DATA, PH_TAIL1, PH_TAIL2, PH_DONE, PH_FAULT
    } t_phase;

    t_phase               r_phase,  n_phase;
    logic [SIZE_BITS-1:0] r_remain, n_remain;
    logic                 r_has_digit, n_has_digit;
    logic                 r_sole_zero, n_sole_zero;
    t_status              r_fault,  n_fault;

    t_out                 r_fifo [FifoDepth];
    logic [PtrBits-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntBits-1:0]   r_count,  n_count;

    logic                 in_acc, out_acc;
    logic [1:0]           res_num;
    t_out                 res0, res1, stat_res;
    t_hex                 hx;
    logic [7:0]           b;
    logic                 take;
    t_status              st;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = (r_count <= CntBits'(FifoDepth - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_fifo[r_rd_ptr];

    assign b  = i_data.in_byte;
    assign hx = hex_decode(b);

    always_comb begin
        n_phase     = r_phase;
        n_remain    = r_remain;
        n_has_digit = r_has_digit;
        n_sole_zero = r_sole_zero;
        n_fault     = r_fault;
        take        = 1'b0;
        res0        = '0;
        res1        = '0;
        res_num     = 2'd0;
        st          = ST_OK;
        stat_res    = '0;

        unique case (r_phase)
            PH_START, PH_LEAD: begin
                if (b == CH_SPACE || b == CH_TAB) begin
                    n_phase = PH_LEAD;
                end else if (hx.valid) begin
                    take        = 1'b1;
                    n_sole_zero = (hx.value == 4'd0);
                    n_phase     = PH_DIGITS;
                end else if (b == CH_CR) begin
                    n_phase = PH_CR;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_DIGITS: begin
                if (hx.valid) begin
                    take        = 1'b1;
                    n_sole_zero = 1'b0;
                end else if ((b == CH_X_LO || b == CH_X_UP) && r_sole_zero) begin
                    n_sole_zero = 1'b0;
                end else if (b == CH_CR) begin
                    n_phase = PH_CR;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (b == CH_CR) begin
                    n_phase = PH_CR;
                end
            end
            PH_CR: begin
                if (b == CH_LF) begin
                    if (!r_has_digit) begin
                        n_fault = ST_NODIGIT;
                        n_phase = PH_FAULT;
                    end else if (r_fault == ST_OVERFLOW) begin
                        n_phase = PH_FAULT;
                    end else if (r_remain == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (b != CH_CR) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_DATA: begin
                res0.out_byte = b;
                res_num       = 2'd1;
                n_remain      = r_remain - SIZE_BITS'(1);
                if (r_remain == SIZE_BITS'(1)) begin
                    n_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                n_phase = PH_TAIL2;
            end
            PH_TAIL2: begin
                n_phase     = PH_START;
                n_remain    = '0;
                n_has_digit = 1'b0;
                n_sole_zero = 1'b0;
                n_fault     = ST_OK;
            end
            default: begin
            end
        endcase

        // digit accumulate; overflow is sticky and stops accumulation
        if (take) begin
            n_has_digit = 1'b1;
            if (r_fault != ST_OVERFLOW) begin
                if (r_remain[SIZE_BITS-1 -: 4] != 4'd0) begin
                    n_fault = ST_OVERFLOW;
                end else begin
                    n_remain = {r_remain[SIZE_BITS-5:0], hx.value};
                end
            end
        end

        if (i_data.in_end) begin
            unique case (n_phase)
                PH_LEAD, PH_DIGITS, PH_SKIP, PH_CR: st = ST_UNTERM;
                PH_DATA:                            st = ST_TRUNC;
                PH_FAULT:                           st = n_fault;
                default:                            st = ST_OK;
            endcase
            stat_res.out_kind = 1'b1;
            stat_res.status   = st;
            stat_res.out_last = 1'b1;
            if (res_num == 2'd1) begin
                res1    = stat_res;
                res_num = 2'd2;
            end else begin
                res0    = stat_res;
                res_num = 2'd1;
            end
            n_phase     = PH_START;
            n_remain    = '0;
            n_has_digit = 1'b0;
            n_sole_zero = 1'b0;
            n_fault     = ST_OK;
        end else begin
            res0.out_last = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + CntBits'(res_num);
        end
        if (out_acc) begin
            n_count = n_count - CntBits'(1);
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_remain    <= '0;
            r_has_digit <= 1'b0;
            r_sole_zero <= 1'b0;
            r_fault     <= ST_OK;
        end else if (in_acc) begin
            r_phase     <= n_phase;
            r_remain    <= n_remain;
            r_has_digit <= n_has_digit;
            r_sole_zero <= n_sole_zero;
            r_fault     <= n_fault;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + PtrBits'(res_num);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PtrBits'(1);
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && res_num != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_acc && res_num == 2'd2) begin
            r_fifo[r_wr_ptr + PtrBits'(1)] <= res1;
        end
    end

    `CTD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntBits'(FifoDepth))
    `CTD_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, in_acc && i_data.in_end,
        r_phase == PH_START && r_remain == '0 && r_fault == ST_OK)
    `CTD_ASSERT_NOW(a_payload_clean, i_clk, i_rst_n, o_valid && !o_data.out_kind,
        o_data.status == ST_OK)
    `CTD_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_valid && o_data.out_kind,
        o_data.out_last && o_data.out_byte == 8'd0)

endmodule

### verif/chunked_transfer_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_tb
// Self-checking bench: chunked bodies, well formed and broken, go in one byte
// per item; a local decoder model predicts each payload and status result.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_tb;
    import ctd_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          RESET_CYCLES = 2;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 200;

    localparam logic [CTD_SIZE_BITS-1:0] SIZE_ALL_ONES = '1;
    localparam logic [7:0]               CH_ZERO       = 8'h30;

    typedef logic [7:0] t_bytes[$];

    typedef enum logic [3:0] {
        LINE_START,
        LINE_BLANKS,
        LINE_DIGITS,
        LINE_SKIP,
        LINE_CR,
        CHUNK_DATA,
        CHUNK_TAIL1,
        CHUNK_TAIL2,
        BODY_DONE,
        BODY_FAULT
    } t_decode_phase;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    chunked_transfer_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // decoder model state
    t_decode_phase              decode_phase   = LINE_START;
    logic [CTD_SIZE_BITS-1:0]   size_left      = '0;
    logic                       got_digit      = 1'b0;
    logic                       zero_prefix_ok = 1'b0;
    t_status                    line_fault     = ST_OK;

    t_out        pending_out[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;
    int unsigned items_sent     = 0;
    int unsigned parsed_items   = 0;
    int unsigned bodies_sent    = 0;
    int unsigned payload_seen   = 0;
    int unsigned status_seen[5] = '{default: 0};

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // model of the decoder
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        decode_phase   = LINE_START;
        size_left      = '0;
        got_digit      = 1'b0;
        zero_prefix_ok = 1'b0;
        line_fault     = ST_OK;
    endfunction

    function automatic void take_digit(input int digit);
        got_digit = 1'b1;
        if (line_fault != ST_OVERFLOW) begin
            if (size_left > (SIZE_ALL_ONES >> 4))
                line_fault = ST_OVERFLOW;
            else
                size_left = {size_left[CTD_SIZE_BITS-5:0], 4'(digit)};
        end
    endfunction

    function automatic void decode_byte(input t_in item);
        logic [7:0] b;
        int         digit;
        t_out       res;
        t_status    st;
        b     = item.in_byte;
        digit = -1;
        if (b >= "0" && b <= "9")
            digit = int'(b) - int'("0");
        else if (b >= "a" && b <= "f")
            digit = int'(b) - int'("a") + 10;
        else if (b >= "A" && b <= "F")
            digit = int'(b) - int'("A") + 10;

        if (decode_phase != BODY_DONE && decode_phase != BODY_FAULT)
            parsed_items++;

        case (decode_phase)
            LINE_START, LINE_BLANKS: begin
                if (b == CH_SPACE || b == CH_TAB) begin
                    decode_phase = LINE_BLANKS;
                end else if (digit >= 0) begin
                    take_digit(digit);
                    zero_prefix_ok = (digit == 0);
                    decode_phase   = LINE_DIGITS;
                end else if (b == CH_CR) begin
                    decode_phase = LINE_CR;
                end else begin
                    decode_phase = LINE_SKIP;
                end
            end
            LINE_DIGITS: begin
                if (digit >= 0) begin
                    take_digit(digit);
                    zero_prefix_ok = 1'b0;
                end else if ((b == CH_X_LO || b == CH_X_UP) && zero_prefix_ok) begin
                    zero_prefix_ok = 1'b0;
                end else if (b == CH_CR) begin
                    decode_phase = LINE_CR;
                end else begin
                    decode_phase = LINE_SKIP;
                end
            end
            LINE_SKIP: begin
                if (b == CH_CR)
                    decode_phase = LINE_CR;
            end
            LINE_CR: begin
                if (b == CH_LF) begin
                    if (!got_digit) begin
                        line_fault   = ST_NODIGIT;
                        decode_phase = BODY_FAULT;
                    end else if (line_fault == ST_OVERFLOW) begin
                        decode_phase = BODY_FAULT;
                    end else if (size_left == 0) begin
                        decode_phase = BODY_DONE;
                    end else begin
                        decode_phase = CHUNK_DATA;
                    end
                end else if (b != CH_CR) begin
                    decode_phase = LINE_SKIP;
                end
            end
            CHUNK_DATA: begin
                res = '{out_byte: b, out_kind: 1'b0, status: ST_OK, out_last: !item.in_end};
                pending_out = {pending_out, res};
                size_left = size_left - 1'b1;
                if (size_left == 0)
                    decode_phase = CHUNK_TAIL1;
            end
            CHUNK_TAIL1: decode_phase = CHUNK_TAIL2;
            CHUNK_TAIL2: clear_parse();
            default: ;
        endcase

        if (item.in_end) begin
            case (decode_phase)
                LINE_BLANKS, LINE_DIGITS, LINE_SKIP, LINE_CR: st = ST_UNTERM;
                CHUNK_DATA: st = ST_TRUNC;
                BODY_FAULT: st = line_fault;
                default:    st = ST_OK;
            endcase
            res = '{out_byte: 8'h00, out_kind: 1'b1, status: st, out_last: 1'b1};
            pending_out = {pending_out, res};
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_out.size() == 0) begin
                errors++;
                $display({"%0t: unexpected result, expected none, ",
                          "got byte %0h kind %0d status %0d last %0d"},
                         $time, o_data.out_byte, o_data.out_kind, o_data.status,
                         o_data.out_last);
            end else begin
                want = pending_out.pop_front();
                check_field("out_byte", want.out_byte, o_data.out_byte);
                check_field("out_kind", 8'(want.out_kind), 8'(o_data.out_kind));
                check_field("status", 8'(want.status), 8'(o_data.status));
                check_field("out_last", 8'(want.out_last), 8'(o_data.out_last));
                if (o_data.out_kind == 1'b0)
                    payload_seen++;
                else if (o_data.status < 3'd5)
                    status_seen[o_data.status]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // valid stays high between back-to-back items; it only drops on an idle cycle
    task automatic send_item(input t_in item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
        decode_byte(item);
    endtask

    task automatic send_body(input t_bytes body);
        t_in item;
        foreach (body[k]) begin
            item.in_byte = body[k];
            item.in_end  = (k == body.size() - 1);
            send_item(item);
        end
        bodies_sent++;
    endtask

    function automatic t_bytes text_bytes(input string s);
        t_bytes q;
        foreach (s[k])
            q = {q, 8'(s[k])};
        return q;
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned v, input bit upper);
        if (v < 10)
            return 8'(int'("0") + v);
        return 8'(int'(upper ? "A" : "a") + v - 10);
    endfunction

    task automatic add_size_line(inout t_bytes body, input int unsigned size);
        int unsigned nib;
        bit          started;
        bit          upper;
        upper = $urandom_range(0, 1);
        repeat ($urandom_range(0, 2))
            body = {body, ($urandom_range(0, 1) ? CH_SPACE : CH_TAB)};
        if ($urandom_range(0, 3) == 0) begin
            body = {body, CH_ZERO, (upper ? CH_X_UP : CH_X_LO)};
        end else if ($urandom_range(0, 4) == 0) begin
            body = {body, CH_ZERO};
        end
        started = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            nib = (size >> (4 * k)) & 32'hF;
            if (nib != 0 || started || k == 0) begin
                started = 1'b1;
                body = {body, hex_char(nib, upper)};
            end
        end
        if ($urandom_range(0, 3) == 0)
            body = {body, text_bytes(";ext=v")};
        body = {body, CH_CR, CH_LF};
    endtask

    // random bodies; about seven in twelve are damaged in some way
    task automatic make_body(output t_bytes body);
        int     len;
        int     cut;
        t_bytes head;
        body = {};
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 8);
            add_size_line(body, len);
            repeat (len)
                body = {body, 8'($urandom_range(0, 255))};
            if ($urandom_range(0, 3) == 0) begin
                body = {body, 8'($urandom_range(0, 255))};
                body = {body, 8'($urandom_range(0, 255))};
            end else begin
                body = {body, CH_CR, CH_LF};
            end
        end
        add_size_line(body, 0);
        if ($urandom_range(0, 2) == 0)
            body = {body, text_bytes("X-T: 1\r\n")};
        body = {body, CH_CR, CH_LF};

        case ($urandom_range(0, 11))
            0, 1: begin
                cut = $urandom_range(1, body.size());
                body = body[0:cut-1];
            end
            2: body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
            3: begin
                // size line of 8 to 11 digits; 9 or more overflow the counter (8 still fit)
                head = {hex_char($urandom_range(1, 15), $urandom_range(0, 1))};
                repeat ($urandom_range(7, 10))
                    head = {head, hex_char($urandom_range(0, 15), $urandom_range(0, 1))};
                head = {head, CH_CR, CH_LF};
                body = {head, body};
            end
            4: body = {text_bytes($urandom_range(0, 1) ? ";ext\r\n" : "+5\r\n"), body};
            5: begin
                body = {};
                repeat ($urandom_range(1, 12))
                    body = {body, 8'($urandom_range(0, 255))};
            end
            6: body.insert($urandom_range(0, body.size() - 1), CH_CR);
            default: ;
        endcase
    endtask

    task automatic run_random_bodies(input int unsigned target);
        int unsigned start;
        t_bytes      body;
        start = items_sent;
        while (items_sent - start < target) begin
            make_body(body);
            send_body(body);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_edge_cases();
        t_bytes body;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // last byte of a chunk also ends the body: payload then ok
        body = text_bytes("1\r\n");
        body = {body, 8'hFF};
        send_body(body);
        // body ends with data still owed
        body = text_bytes("2\r\n");
        body = {body, 8'h00};
        send_body(body);
        send_body(text_bytes("-1\r\n"));
        send_body(text_bytes("FFFFFFFFF\r\n"));
        send_body(text_bytes(" 0x"));
        // lone CR, then the line goes on
        send_body(text_bytes("\r1"));
        send_body(text_bytes("0\r\n"));
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_bodies(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        run_random_bodies(PHASE_ITEMS);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random_bodies(PHASE_ITEMS);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_random_bodies(PHASE_ITEMS);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_cases();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        i_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d bodies, %0d bytes in, %0d parsed, %0d payload bytes out",
                 bodies_sent, items_sent, parsed_items, payload_seen);
        $display({"End status: ok %0d, no digits %0d, overflow %0d, ",
                  "unterminated %0d, truncated %0d"},
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
